// File: src/sui_pkg.sv
// package for the set union / intersection filter
// holds the beat types, command codes, controller state and shared commands
// no dependencies
package sui_pkg;

   // default number of stored set entries
   localparam int DEPTH_DEFAULT = 64;

   // command codes of the request beat
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // mode register codes
   localparam logic MODE_UNION     = 1'b0;
   localparam logic MODE_INTERSECT = 1'b1;

   // saturation point of the result counter
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // request beat
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   // response beat
   typedef struct packed {
      logic signed [31:0] out_value;
      logic               from_query;
      logic [7:0]         result_index;
   } rsp_type;

   // controller state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic do_clear;
      logic do_load;
      logic scan_run;
      logic push;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic mode;
      logic set_full;
      logic hit;
      logic scan_done;
      logic slot_free;
   } ctl_stat_type;

endpackage

// File: src/sui_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sui_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sui_datapath.sv
// datapath: mode register, set store, fill and result counters, scan compare,
// response register; depends on sui_pkg and sui_ram
module sui_datapath #(
   parameter int DEPTH = sui_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sui_pkg::req_type      req_data,
   input  logic                  csr_valid,
   input  logic                  csr_data,
   input  sui_pkg::ctl_cmd_type  cmd,
   output sui_pkg::ctl_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sui_pkg::rsp_type      rsp_data
);
   import sui_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

   logic              mode_ff, mode_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        count_ff, count_in;
   logic [FILL_W-1:0] rd_idx_ff, rd_idx_in;
   logic              cmp_pend_ff, cmp_pend_in;
   logic [31:0]       value_ff, value_in;
   logic              is_query_ff, is_query_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              set_full;
   logic              wr_en;
   logic              issue;
   logic              hit;
   logic [31:0]       rd_data;

   // set store
   sui_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // load and scan control
   always_comb begin
      set_full = (fill_ff == FILL_MAX);
      wr_en    = cmd.do_load && !set_full;
      hit      = cmp_pend_ff && (rd_data == value_ff);
      issue    = cmd.scan_run && !hit && (rd_idx_ff < fill_ff);
   end

   // mode register
   always_comb begin
      mode_in = csr_valid ? csr_data : mode_ff;
   end

   // fill and result counters
   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      if (cmd.do_clear) begin
         fill_in  = '0;
         count_in = '0;
      end else begin
         if (wr_en) begin
            fill_in = fill_ff + 1'b1;
         end
         if (cmd.push && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // item capture and scan pointer
   always_comb begin
      value_in    = value_ff;
      is_query_in = is_query_ff;
      rd_idx_in   = rd_idx_ff;
      cmp_pend_in = issue;
      if (cmd.accept) begin
         value_in    = req_data.value;
         is_query_in = (req_data.cmd == CMD_QUERY);
         rd_idx_in   = '0;
         cmp_pend_in = 1'b0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   // response register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.push) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_value    = value_ff;
         rsp_data_in.from_query   = is_query_ff && (mode_ff == MODE_UNION);
         rsp_data_in.result_index = count_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNION;
         fill_ff      <= '0;
         count_ff     <= '0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         cmp_pend_ff  <= cmp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      is_query_ff <= is_query_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to controller
   always_comb begin
      stat.mode      = mode_ff;
      stat.set_full  = set_full;
      stat.hit       = hit;
      stat.scan_done = !cmp_pend_ff && (rd_idx_ff >= fill_ff);
      stat.slot_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill count never passes the store depth
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("set fill count beyond depth");

   // a saturated result counter stays saturated until a clear
   a_count_sat : assert property (@(posedge clock) disable iff (reset)
      (count_ff == COUNT_MAX && !cmd.do_clear) |=> (count_ff == COUNT_MAX))
      else $error("result counter left saturation");

   // a new response only goes into a free output slot
   a_push_free : assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

   // the scan pointer never runs past the fill count
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      cmd.scan_run |-> (rd_idx_ff <= fill_ff))
      else $error("scan pointer beyond fill");

endmodule

// File: src/sui_ctrl.sv
// controller state machine: takes request beats, runs the set scan,
// hands results to the response register; depends on sui_pkg
module sui_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  sui_pkg::ctl_stat_type stat,
   output sui_pkg::ctl_cmd_type  cmd
);
   import sui_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_QUERY) begin
                  state_in = ST_SCAN;
               end else if (req_cmd == CMD_LOAD && !stat.set_full
                            && stat.mode == MODE_UNION) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            priority if (stat.hit) begin
               state_in = (stat.mode == MODE_INTERSECT) ? ST_EMIT : ST_IDLE;
            end else if (stat.scan_done) begin
               state_in = (stat.mode == MODE_UNION) ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (stat.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.accept   = accept;
      cmd.do_clear = accept && (req_cmd == CMD_CLEAR);
      cmd.do_load  = accept && (req_cmd == CMD_LOAD);
      cmd.scan_run = (state_ff == ST_SCAN);
      cmd.push     = (state_ff == ST_EMIT) && stat.slot_free;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // requests are only taken while idle
   a_accept_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (state_ff == ST_IDLE))
      else $error("request taken outside idle");

   // a query always goes into a scan
   a_query_scan : assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_QUERY) |=> (state_ff == ST_SCAN))
      else $error("query did not start a scan");

   // a result leaves the emit state at once when the slot is free
   a_emit_exit : assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (state_ff == ST_IDLE))
      else $error("emit state held after push");

endmodule

// File: src/set_union_intersection_filter_core.sv
// set union / intersection filter, top level
// depends on sui_pkg, sui_ctrl, sui_datapath, sui_ram
//
// usage:
//   req channel: one beat carries a command (clear, load, query) and a value.
//     clear empties the stored set and zeroes the result counter; load stores
//     a value (dropped when the set holds DEPTH values) and in union mode also
//     sends it out; query searches the stored set for the value.
//   rsp channel: zero or one beat per request, with the value, a union-mode
//     query flag and its running result index (saturates at 255).
//   csr channel: one-bit mode, 0 union, 1 intersection; always ready, write
//     only while no request is in flight.
// order of work:
//   clear and load act on the accepted beat; a load that sends a result
//   then passes through the emit state. a query scans the set store one
//   entry per cycle through its registered read port until the first match
//   or the last filled entry, then sends any result through the emit state.
// reset: synchronous, clears the set fill, result counter, mode and handshakes;
//   the set store itself is not cleared, only filled entries are read.
// stall: a result waits in the output register; the block takes the next
//   request meanwhile and only holds when it has a further result to send.
module set_union_intersection_filter_core #(
   parameter int DEPTH = sui_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sui_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sui_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import sui_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   assign csr_ready = 1'b1;

   // controller
   sui_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   sui_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
